// ===== rtl/cabsm_pkg.sv =====
package cabsm_pkg;

  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;
  localparam int SLOTS   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    FUNC_RESERVE = 2'd0,
    FUNC_PUT     = 2'd1,
    FUNC_GET     = 2'd2,
    FUNC_UNGET   = 2'd3
  } func_t;

  typedef logic [SLOTS-1:0][COUNT_W-1:0] counters_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot_out;
    logic [COUNT_W-1:0] link_count;
  } result_t;

  typedef struct packed {
    logic               cnt_we;
    logic [SLOT_W-1:0]  cnt_idx;
    logic [COUNT_W-1:0] cnt_val;
    logic               head_we;
    logic [SLOT_W-1:0]  head_val;
  } update_t;

endpackage

// ===== rtl/cabsm_ifs.sv =====
interface cabsm_req_if
  import cabsm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output func, output slot, input ready);
  modport sink (input valid, input func, input slot, output ready);
endinterface

interface cabsm_rsp_if
  import cabsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  slot_out;
  logic [COUNT_W-1:0] link_count;

  modport source (output valid, output ok, output slot_out, output link_count, input ready);
  modport sink (input valid, input ok, input slot_out, input link_count, output ready);
endinterface

// ===== rtl/cabsm_core.sv =====
module cabsm_core
  import cabsm_pkg::*;
#(
  parameter int NUM_TASKS = 7
) (
  input  counters_t          counters,
  input  logic [SLOT_W-1:0]  head,
  input  logic [1:0]         func,
  input  logic [SLOT_W-1:0]  slot,
  output result_t            result,
  output update_t            update
);

  localparam int SlotCount = (NUM_TASKS + 1 < SLOTS) ? NUM_TASKS + 1 : SLOTS;
  localparam logic [SLOT_W:0] SlotLim = (SLOT_W + 1)'(SlotCount);

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              slot_in_range;
  logic              head_in_range;
  logic [COUNT_W-1:0] slot_cnt;
  logic [COUNT_W-1:0] head_cnt;
  func_t             op;

  assign op            = func_t'(func);
  assign slot_in_range = {1'b0, slot} < SlotLim;
  assign head_in_range = {1'b0, head} < SlotLim;
  assign slot_cnt      = counters[slot];
  assign head_cnt      = counters[head];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!free_found && (i < SlotCount) && (counters[i] == '0) &&
          (head != SLOT_W'(i))) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    result = '0;
    update = '0;
    unique case (op)
      FUNC_RESERVE: begin
        if (free_found) begin
          result = '{ok: 1'b1, slot_out: free_idx, link_count: COUNT_W'(1)};
          update.cnt_we  = 1'b1;
          update.cnt_idx = free_idx;
          update.cnt_val = COUNT_W'(1);
        end
      end
      FUNC_PUT: begin
        result.slot_out = slot;
        if (slot_in_range) begin
          result.ok       = 1'b1;
          update.cnt_we   = 1'b1;
          update.cnt_idx  = slot;
          update.cnt_val  = '0;
          update.head_we  = 1'b1;
          update.head_val = slot;
        end
      end
      FUNC_GET: begin
        result.slot_out = head;
        if (head_in_range) begin
          result.ok      = 1'b1;
          update.cnt_we  = 1'b1;
          update.cnt_idx = head;
          update.cnt_val = (head_cnt == COUNT_MAX) ? head_cnt : head_cnt + 1'b1;
          result.link_count = update.cnt_val;
        end
      end
      FUNC_UNGET: begin
        result.slot_out = slot;
        if (slot_in_range && slot_cnt != '0) begin
          result.ok      = 1'b1;
          update.cnt_we  = 1'b1;
          update.cnt_idx = slot;
          update.cnt_val = slot_cnt - 1'b1;
          result.link_count = update.cnt_val;
        end
      end
      default: begin
        result = '0;
        update = '0;
      end
    endcase
  end

endmodule

// ===== rtl/cyclic_async_buffer_slot_manager_unit.sv =====
// Channel  Dir  Fields                      Handshake
// req      in   func, slot                  valid/ready
// rsp      out  ok, slot_out, link_count    valid/ready
// cfg      in   cfg_data (first_slot)       cfg_we, no wait
//
// One request per cycle sustained while rsp accepts; a result is offered after
// accept through the input register, then the result register. The counter file
// update and the result register load happen on the same edge, so back-to-back
// requests see each other's effect. Reset clears all counters and sets the head to 0.
// A stalled rsp holds the result and lets one more request into the input
// register before req.ready drops.
module cyclic_async_buffer_slot_manager_unit
  import cabsm_pkg::*;
#(
  parameter int NUM_TASKS = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_data,
  cabsm_req_if.sink         req,
  cabsm_rsp_if.source       rsp
);

  logic              in_valid;
  logic [1:0]        in_func;
  logic [SLOT_W-1:0] in_slot;
  logic              out_valid;
  result_t           out_res;
  counters_t         counters;
  logic [SLOT_W-1:0] head;
  logic              advance;
  result_t           res_next;
  update_t           upd;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  cabsm_core #(.NUM_TASKS(NUM_TASKS)) u_core (
    .counters (counters),
    .head     (head),
    .func     (in_func),
    .slot     (in_slot),
    .result   (res_next),
    .update   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_func <= req.func;
      in_slot <= req.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // first_slot only seeds the head, so the head register is all that is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      counters <= '0;
      head     <= '0;
    end else begin
      if (cfg_we) begin
        head <= cfg_data;
      end else if (advance && upd.head_we) begin
        head <= upd.head_val;
      end
      if (advance && upd.cnt_we) begin
        counters[upd.cnt_idx] <= upd.cnt_val;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_res.ok;
  assign rsp.slot_out   = out_res.slot_out;
  assign rsp.link_count = out_res.link_count;

endmodule

// ===== test/tb_cyclic_async_buffer_slot_manager_unit.sv =====
`timescale 1ns / 1ps

module tb_cyclic_async_buffer_slot_manager_unit;
  import cabsm_pkg::*;

  localparam int NUM_TASKS       = 7;
  localparam int SLOT_LIMIT      = (NUM_TASKS + 1 < SLOTS) ? NUM_TASKS + 1 : SLOTS;
  localparam int ITEMS_PER_PHASE = 480;
  localparam int PRESSURE_ITEMS  = 40;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 4000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    func_t              func;
    logic [SLOT_W-1:0]  slot;
    int                 reps;
    bit                 typed;
    result_t            want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SLOT_W-1:0] cfg_data;

  cabsm_req_if req_ch ();
  cabsm_rsp_if rsp_ch ();

  cyclic_async_buffer_slot_manager_unit #(
    .NUM_TASKS(NUM_TASKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source)
  );

  // predictor state
  logic [COUNT_W-1:0] link_cnt [SLOTS];
  logic [SLOT_W-1:0]  head_slot;

  result_t due_results [$];

  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt  = 0;

  int n_errors     = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_reserve    = 0;
  int n_no_free    = 0;
  int n_put        = 0;
  int n_get        = 0;
  int n_saturated  = 0;
  int n_unget      = 0;
  int n_unget_zero = 0;
  int n_cfg        = 0;

  dir_row_t dir_rows [0:9] = '{
    '{FUNC_GET,     3'd0, 1,  1'b1, '{1'b1, 3'd0, 4'd1}},
    '{FUNC_GET,     3'd0, 14, 1'b0, '{1'b0, 3'd0, 4'd0}},
    '{FUNC_GET,     3'd0, 1,  1'b1, '{1'b1, 3'd0, 4'd15}},
    '{FUNC_UNGET,   3'd0, 1,  1'b1, '{1'b1, 3'd0, 4'd14}},
    '{FUNC_UNGET,   3'd1, 1,  1'b1, '{1'b0, 3'd1, 4'd0}},
    '{FUNC_UNGET,   3'd7, 1,  1'b1, '{1'b0, 3'd7, 4'd0}},
    '{FUNC_PUT,     3'd0, 1,  1'b1, '{1'b1, 3'd0, 4'd0}},
    '{FUNC_RESERVE, 3'd0, 1,  1'b1, '{1'b1, 3'd1, 4'd1}},
    '{FUNC_RESERVE, 3'd7, 6,  1'b0, '{1'b0, 3'd0, 4'd0}},
    '{FUNC_RESERVE, 3'd0, 1,  1'b1, '{1'b0, 3'd0, 4'd0}}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d (request %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic result_t book_request(func_t f, logic [SLOT_W-1:0] s);
    result_t r;
    bit found;
    r = '0;
    found = 1'b0;
    case (f)
      FUNC_RESERVE: begin
        n_reserve++;
        for (int i = 0; i < SLOT_LIMIT; i++) begin
          if (!found && link_cnt[i] == '0 && head_slot != SLOT_W'(i)) begin
            found = 1'b1;
            link_cnt[i] = COUNT_W'(1);
            r = '{1'b1, SLOT_W'(i), COUNT_W'(1)};
          end
        end
        if (!found) n_no_free++;
      end
      FUNC_PUT: begin
        n_put++;
        r = '{1'b0, s, '0};
        if (int'(s) < SLOT_LIMIT) begin
          head_slot = s;
          link_cnt[s] = '0;
          r.ok = 1'b1;
        end
      end
      FUNC_GET: begin
        n_get++;
        r = '{1'b0, head_slot, '0};
        if (int'(head_slot) < SLOT_LIMIT) begin
          if (link_cnt[head_slot] < COUNT_MAX) link_cnt[head_slot]++;
          else n_saturated++;
          r = '{1'b1, head_slot, link_cnt[head_slot]};
        end
      end
      default: begin
        n_unget++;
        r = '{1'b0, s, '0};
        if (int'(s) >= SLOT_LIMIT || link_cnt[s] == '0) begin
          n_unget_zero++;
        end else begin
          link_cnt[s]--;
          r = '{1'b1, s, link_cnt[s]};
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input func_t f, input logic [SLOT_W-1:0] s, input bit typed,
                          input result_t want, output result_t pred);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 85 : (idle_mode == IDLE_BOTH) ? 22 : 0;
    if ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.slot  <= s;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = book_request(f, s);
    due_results.push_back(typed ? want : pred);
    n_requests++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_slot(input logic [SLOT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    head_slot = v;
    n_cfg++;
  endtask

  // writers reserve then put, readers get then mostly unget; some noise
  task automatic run_random(input int n_items);
    int done;
    int pick;
    result_t r;
    result_t none;
    logic [SLOT_W-1:0] s;
    done = 0;
    none = '0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_req(FUNC_RESERVE, SLOT_W'($urandom), 1'b0, none, r);
        s = (r.ok && $urandom_range(9) != 0) ? r.slot_out : SLOT_W'($urandom);
        send_req(FUNC_PUT, s, 1'b0, none, r);
        done += 2;
      end else if (pick < 70) begin
        send_req(FUNC_GET, SLOT_W'($urandom), 1'b0, none, r);
        s = r.slot_out;
        done++;
        if ($urandom_range(99) < 60) begin
          send_req(FUNC_UNGET, s, 1'b0, none, r);
          done++;
        end
      end else if (pick < 74) begin
        repeat (16) send_req(FUNC_GET, SLOT_W'($urandom), 1'b0, none, r);
        done += 16;
      end else begin
        send_req(func_t'(2'($urandom_range(3))), SLOT_W'($urandom), 1'b0, none, r);
        done++;
      end
    end
  endtask

  // result side: ready pattern, long hold, check
  initial begin
    result_t got;
    result_t want;
    int stall_pct;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.ok, rsp_ch.slot_out, rsp_ch.link_count};
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(got), 0);
        end else begin
          want = due_results.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.slot_out !== want.slot_out)
            report_mismatch("slot_out", got.slot_out, want.slot_out);
          if (got.link_count !== want.link_count)
            report_mismatch("link_count", got.link_count, want.link_count);
        end
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 85 : (idle_mode == IDLE_BOTH) ? 22 : 0;
      if (hold_go && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    result_t r;
    logic [SLOT_W-1:0] cfg_vals [4];
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_RESERVE;
    req_ch.slot  = '0;
    head_slot    = '0;
    for (int i = 0; i < SLOTS; i++) link_cnt[i] = '0;
    cfg_vals[0] = 3'd7;
    cfg_vals[1] = 3'd0;
    cfg_vals[2] = SLOT_W'($urandom_range(1, 6));
    cfg_vals[3] = SLOT_W'($urandom);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(dir_rows); i++)
      repeat (dir_rows[i].reps)
        send_req(dir_rows[i].func, dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].want, r);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_first_slot(cfg_vals[p]);
      idle_mode = idle_mode_t'(p);
      run_random(ITEMS_PER_PHASE);
    end

    // receiver holds off while requests keep coming
    wait_drained();
    idle_mode = IDLE_NONE;
    hold_go   = 1'b1;
    run_random(PRESSURE_ITEMS);

    wait_drained();
    if (due_results.size() != 0)
      report_mismatch("results never returned", due_results.size(), 0);

    $display("run: %0d requests, %0d results, %0d first_slot writes, %0d mismatches",
             n_requests, n_results, n_cfg, n_errors);
    $display("mix: rsv %0d (none %0d), put %0d, get %0d (sat %0d), unget %0d (fail %0d)",
             n_reserve, n_no_free, n_put, n_get, n_saturated, n_unget, n_unget_zero);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
